>>> rtl/vrn_pkg.sv
// Package for the vector reflection unit: default widths, result status codes
// and the control word that travels beside each request in the pipeline.
// No dependencies.
package vrn_pkg;

  localparam int COMP_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } vrn_status_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } vrn_ctl_t;

endpackage

>>> rtl/vrn_if.sv
// Valid/ready channel interfaces of the vector reflection unit: the request
// channel (direction and normal) and the result channel. Depends on vrn_pkg.
interface vrn_in_if #(
  parameter int COMP_WIDTH = vrn_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] dir_x;
  logic signed [COMP_WIDTH-1:0] dir_y;
  logic signed [COMP_WIDTH-1:0] dir_z;
  logic signed [COMP_WIDTH-1:0] normal_x;
  logic signed [COMP_WIDTH-1:0] normal_y;
  logic signed [COMP_WIDTH-1:0] normal_z;

  modport source (
    output valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

interface vrn_out_if #(
  parameter int COMP_WIDTH = vrn_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] out_x;
  logic signed [COMP_WIDTH-1:0] out_y;
  logic signed [COMP_WIDTH-1:0] out_z;
  logic [1:0]                   status;

  modport source (
    output valid, out_x, out_y, out_z, status,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, status,
    output ready
  );
endinterface

>>> rtl/vrn_div.sv
// Pipelined restoring divider of the reflection unit: one quotient bit per
// register stage, with the request's control word and payload carried along.
// Depends on vrn_pkg.
module vrn_div #(
  parameter int COMP_WIDTH = vrn_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = vrn_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W     = 6 * vrn_pkg::COMP_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  vrn_pkg::vrn_ctl_t                ctl_i,
  input  logic [2*COMP_WIDTH-1:0]          den_i,
  input  logic [2*COMP_WIDTH-1:0]          rem_i,
  input  logic [COMP_WIDTH+FRAC_BITS:0]    rq_i,
  input  logic [SIDE_W-1:0]                side_i,
  output vrn_pkg::vrn_ctl_t                ctl_o,
  output logic [COMP_WIDTH+FRAC_BITS:0]    q_o,
  output logic [SIDE_W-1:0]                side_o
);
  import vrn_pkg::*;

  localparam int DW = 2 * COMP_WIDTH;
  localparam int QW = COMP_WIDTH + FRAC_BITS + 1;

  vrn_ctl_t          ctl_r  [QW];
  logic [DW-1:0]     den_r  [QW];
  logic [DW-1:0]     rem_r  [QW];
  logic [QW-1:0]     rq_r   [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    vrn_ctl_t          ctl_nxt;
    logic [DW-1:0]     den_nxt;
    logic [DW-1:0]     rem_cur;
    logic [QW-1:0]     rq_cur;
    logic [SIDE_W-1:0] side_nxt;
    logic [DW:0]       trial;
    logic              take;
    logic [DW-1:0]     rem_nxt;
    logic [QW-1:0]     rq_nxt;

    if (k == 0) begin : g_first
      assign ctl_nxt  = ctl_i;
      assign den_nxt  = den_i;
      assign rem_cur  = rem_i;
      assign rq_cur   = rq_i;
      assign side_nxt = side_i;
    end else begin : g_next
      assign ctl_nxt  = ctl_r[k-1];
      assign den_nxt  = den_r[k-1];
      assign rem_cur  = rem_r[k-1];
      assign rq_cur   = rq_r[k-1];
      assign side_nxt = side_r[k-1];
    end

    // The partial remainder stays below the divisor, so the difference fits DW bits.
    always_comb begin
      trial   = {rem_cur, rq_cur[QW-1]};
      take    = (trial >= {1'b0, den_nxt});
      rem_nxt = take ? (trial[DW-1:0] - den_nxt) : trial[DW-1:0];
      rq_nxt  = {rq_cur[QW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (en) begin
        ctl_r[k] <= ctl_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_nxt;
        rem_r[k]  <= rem_nxt;
        rq_r[k]   <= rq_nxt;
        side_r[k] <= side_nxt;
      end
    end
  end

  assign ctl_o  = ctl_r[QW-1];
  assign q_o    = rq_r[QW-1];
  assign side_o = side_r[QW-1];

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[QW-1].valid && !ctl_r[QW-1].zero |-> rem_r[QW-1] < den_r[QW-1])
    else $error("divider remainder not below divisor");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    en && ctl_i.valid |=> ctl_r[0].valid)
    else $error("request lost on entry to divider");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_r[QW-1]) && $stable(rq_r[QW-1]))
    else $error("divider output changed while stalled");
`endif

endmodule

>>> rtl/vector_reflect_about_normal_unit.sv
// Vector reflection unit: mirrors a Q-format direction about a normal of any length.
// A request passes p1, p2, p3, the divider that resolves one quotient bit per stage,
// then m1, m2, m3 and the output register; one request per cycle unless results stall.
// An input skid register holds one request while results wait.
// Reset is synchronous, active low, and clears the valid bits, the skid valid included.
// Depends on vrn_pkg, vrn_if and vrn_div.
module vector_reflect_about_normal_unit #(
  parameter int COMP_WIDTH = vrn_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = vrn_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vrn_in_if.sink    in_req,
  vrn_out_if.source out_rsp
);
  import vrn_pkg::*;

  localparam int CW     = COMP_WIDTH;
  localparam int PW     = 2 * CW;
  localparam int DTW    = 2 * CW + 1;
  localparam int QW     = CW + FRAC_BITS + 1;
  localparam int QLW    = (QW + 1) / 2;
  localparam int QHW    = QW - QLW;
  localparam int TW     = CW + 3;
  localparam int OW     = CW + 4;
  localparam int SIDE_W = 6 * CW;

  localparam logic signed [OW-1:0] O_MAX = OW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] O_MIN = OW'(-(64'sd1 <<< (CW - 1)));
  localparam logic [CW-1:0]        S_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        S_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][CW-1:0] dir;
    logic [2:0][CW-1:0] nrm;
  } side_t;

  logic  en;
  logic  src_vld;
  side_t in_side;
  side_t src_side;
  logic  skid_vld_r, skid_vld_nxt;
  side_t skid_side_r;

  logic                  p1_vld_r;
  side_t                 p1_side_r;
  logic signed [PW-1:0]  p1_dot_r [3];
  logic signed [PW-1:0]  p1_nsq_r [3];
  logic signed [PW-1:0]  p1_dot_nxt [3];
  logic signed [PW-1:0]  p1_nsq_nxt [3];

  logic                  p2_vld_r;
  side_t                 p2_side_r;
  logic signed [DTW-1:0] p2_dot_r, p2_dot_nxt;
  logic [PW-1:0]         p2_nn_r, p2_nn_nxt;

  vrn_ctl_t              p3_ctl_r, p3_ctl_nxt;
  side_t                 p3_side_r;
  logic [PW-1:0]         p3_mag_r, p3_mag_nxt;
  logic [PW-1:0]         p3_nn_r;
  logic signed [DTW-1:0] dot_abs;

  vrn_ctl_t              d_ctl;
  logic [QW-1:0]         d_q;
  logic [SIDE_W-1:0]     d_side_bits;
  side_t                 d_side;

  vrn_ctl_t              m1_ctl_r;
  side_t                 m1_side_r;
  logic [2:0]            m1_sgn_r, m1_sgn_nxt;
  logic [QLW+CW-1:0]     m1_pl_r [3];
  logic [QHW+CW-1:0]     m1_ph_r [3];
  logic [QLW+CW-1:0]     m1_pl_nxt [3];
  logic [QHW+CW-1:0]     m1_ph_nxt [3];
  logic [CW-1:0]         nrm_mag [3];

  vrn_ctl_t              m2_ctl_r;
  side_t                 m2_side_r;
  logic [2:0]            m2_sgn_r;
  logic [QW-1:0]         m2_m_r [3];
  logic [QW-1:0]         m2_m_nxt [3];
  logic [QW+CW-1:0]      m_full [3];

  vrn_ctl_t              m3_ctl_r;
  side_t                 m3_side_r;
  logic signed [TW-1:0]  m3_t_r [3];
  logic signed [TW-1:0]  m3_t_nxt [3];
  logic [TW-1:0]         t_mag [3];

  logic                  out_vld_r;
  logic [CW-1:0]         out_val_r [3];
  logic [CW-1:0]         out_val_nxt [3];
  vrn_status_t           out_sts_r, out_sts_nxt;
  logic signed [OW-1:0]  diff [3];
  logic [2:0]            clip;

  // Input side: the skid register holds one request while the pipeline is stalled.
  assign in_side.dir[0] = in_req.dir_x;
  assign in_side.dir[1] = in_req.dir_y;
  assign in_side.dir[2] = in_req.dir_z;
  assign in_side.nrm[0] = in_req.normal_x;
  assign in_side.nrm[1] = in_req.normal_y;
  assign in_side.nrm[2] = in_req.normal_z;

  assign en           = !out_vld_r || out_rsp.ready;
  assign src_vld      = skid_vld_r || in_req.valid;
  assign src_side     = skid_vld_r ? skid_side_r : in_side;
  assign in_req.ready = !skid_vld_r;
  assign skid_vld_nxt = skid_vld_r ? !en : (in_req.valid && !en);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_dot_nxt[i] = $signed(src_side.dir[i]) * $signed(src_side.nrm[i]);
      p1_nsq_nxt[i] = $signed(src_side.nrm[i]) * $signed(src_side.nrm[i]);
    end
  end

  always_comb begin
    p2_dot_nxt = DTW'(p1_dot_r[0]) + DTW'(p1_dot_r[1]) + DTW'(p1_dot_r[2]);
    p2_nn_nxt  = p1_nsq_r[0][PW-1:0] + p1_nsq_r[1][PW-1:0] + p1_nsq_r[2][PW-1:0];
  end

  always_comb begin
    dot_abs          = p2_dot_r[DTW-1] ? -p2_dot_r : p2_dot_r;
    p3_mag_nxt       = dot_abs[PW-1:0];
    p3_ctl_nxt.valid = p2_vld_r;
    p3_ctl_nxt.neg   = p2_dot_r[DTW-1];
    p3_ctl_nxt.zero  = (p2_nn_r == '0);
  end

  // The quotient 2*|a.n|*2^FRAC_BITS / n.n stays below 2^QW, so the top bits of
  // the dividend start as the partial remainder.
  vrn_div #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .SIDE_W     (SIDE_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (p3_ctl_r),
    .den_i  (p3_nn_r),
    .rem_i  ({{CW{1'b0}}, p3_mag_r[PW-1:CW]}),
    .rq_i   ({p3_mag_r[CW-1:0], {(FRAC_BITS+1){1'b0}}}),
    .side_i (p3_side_r),
    .ctl_o  (d_ctl),
    .q_o    (d_q),
    .side_o (d_side_bits)
  );

  assign d_side = d_side_bits;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_mag[i]    = d_side.nrm[i][CW-1] ? (~d_side.nrm[i] + 1'b1) : d_side.nrm[i];
      m1_pl_nxt[i]  = d_q[QLW-1:0] * nrm_mag[i];
      m1_ph_nxt[i]  = d_q[QW-1:QLW] * nrm_mag[i];
      m1_sgn_nxt[i] = d_ctl.neg ^ d_side.nrm[i][CW-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_full[i]   = {m1_ph_r[i], {QLW{1'b0}}} + (QW+CW)'(m1_pl_r[i]);
      m2_m_nxt[i] = m_full[i][QW-1:0];
    end
  end

  // A negative scaled normal rounds its magnitude up, which floors the signed value.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_mag[i]    = TW'(m2_m_r[i][QW-1:FRAC_BITS])
                  + TW'(m2_sgn_r[i] && (m2_m_r[i][FRAC_BITS-1:0] != '0));
      m3_t_nxt[i] = m2_sgn_r[i] ? -$signed(t_mag[i]) : $signed(t_mag[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = OW'($signed(m3_side_r.dir[i])) - OW'(m3_t_r[i]);
      clip[i] = (diff[i] > O_MAX) || (diff[i] < O_MIN);
      if (m3_ctl_r.zero) begin
        out_val_nxt[i] = m3_side_r.dir[i];
      end else if (diff[i] > O_MAX) begin
        out_val_nxt[i] = S_MAX;
      end else if (diff[i] < O_MIN) begin
        out_val_nxt[i] = S_MIN;
      end else begin
        out_val_nxt[i] = diff[i][CW-1:0];
      end
    end
    if (m3_ctl_r.zero) begin
      out_sts_nxt = ST_ZERO;
    end else if (clip != '0) begin
      out_sts_nxt = ST_SAT;
    end else begin
      out_sts_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
      p3_ctl_r   <= '0;
      m1_ctl_r   <= '0;
      m2_ctl_r   <= '0;
      m3_ctl_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
      if (en) begin
        p1_vld_r  <= src_vld;
        p2_vld_r  <= p1_vld_r;
        p3_ctl_r  <= p3_ctl_nxt;
        m1_ctl_r  <= d_ctl;
        m2_ctl_r  <= m1_ctl_r;
        m3_ctl_r  <= m2_ctl_r;
        out_vld_r <= m3_ctl_r.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r && in_req.valid && !en) begin
      skid_side_r <= in_side;
    end
    if (en) begin
      p1_side_r <= src_side;
      p1_dot_r  <= p1_dot_nxt;
      p1_nsq_r  <= p1_nsq_nxt;
      p2_side_r <= p1_side_r;
      p2_dot_r  <= p2_dot_nxt;
      p2_nn_r   <= p2_nn_nxt;
      p3_side_r <= p2_side_r;
      p3_mag_r  <= p3_mag_nxt;
      p3_nn_r   <= p2_nn_r;
      m1_side_r <= d_side;
      m1_sgn_r  <= m1_sgn_nxt;
      m1_pl_r   <= m1_pl_nxt;
      m1_ph_r   <= m1_ph_nxt;
      m2_side_r <= m1_side_r;
      m2_sgn_r  <= m1_sgn_r;
      m2_m_r    <= m2_m_nxt;
      m3_side_r <= m2_side_r;
      m3_t_r    <= m3_t_nxt;
      out_val_r <= out_val_nxt;
      out_sts_r <= out_sts_nxt;
    end
  end

  assign out_rsp.valid  = out_vld_r;
  assign out_rsp.out_x  = out_val_r[0];
  assign out_rsp.out_y  = out_val_r[1];
  assign out_rsp.out_z  = out_val_r[2];
  assign out_rsp.status = out_sts_r;

`ifndef SYNTHESIS
  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_sts_r == ST_SAT) |->
      (out_val_r[0] == S_MAX) || (out_val_r[0] == S_MIN) ||
      (out_val_r[1] == S_MAX) || (out_val_r[1] == S_MIN) ||
      (out_val_r[2] == S_MAX) || (out_val_r[2] == S_MIN))
    else $error("saturated result has no clamped component");

  a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready && !en |=> skid_vld_r)
    else $error("stalled request not held in skid register");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && en |=> !skid_vld_r && p1_vld_r)
    else $error("skid register did not drain into the pipeline");
`endif

endmodule
